@@ rtl/bvts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvts_pkg
// Shared types and constants for the best-value table search unit.
// ----------------------------------------------------------------------------
package bvts_pkg;

    localparam int ROWS       = 1024;
    localparam int ROW_BITS   = $clog2(ROWS);
    localparam int COUNT_BITS = $clog2(ROWS + 1);
    localparam int VALUE_BITS = 48;
    localparam int PARAM_BITS = 16;
    localparam int CODE_BITS  = 4;
    localparam int KIND_BITS  = 2;
    localparam int ADDR_BITS  = 4;
    localparam int DATA_BITS  = 64;

    localparam logic [KIND_BITS-1:0] KIND_UPDATE = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_READ   = 2'd2;

    localparam logic [CODE_BITS-1:0] CODE_IDENTITY = 4'd0;

    // Register select is the 8-byte word index of the address.
    localparam logic REG_VALUE_CAP = 1'b0;
    localparam logic REG_ROW_LIMIT = 1'b1;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [CODE_BITS-1:0]  code;
        logic [PARAM_BITS-1:0] param_a;
        logic [PARAM_BITS-1:0] param_b;
        logic [PARAM_BITS-1:0] param_c;
        logic [PARAM_BITS-1:0] param_d;
        logic [PARAM_BITS-1:0] param_e;
    } t_row;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_PROBE
    } t_state;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_UPDATE,
        RES_MISS,
        RES_FOUND_MID,
        RES_FOUND_LO,
        RES_READ
    } t_res;

    typedef struct packed {
        logic clear;
        logic load;
        logic wr_row;
        logic srch_start;
        logic probe;
        logic done;
        t_res res_sel;
    } t_ctl_cmd;

    typedef struct packed {
        logic                 clear_last;
        logic [KIND_BITS-1:0] kind;
        logic                 upd_ok;
        logic                 miss;
        logic                 probe_eq;
        logic                 probe_more;
    } t_dp_status;

endpackage

@@ rtl/bvts_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvts_ctrl
// Controller: sequences the clearing pass, the row check and the search probes.
// ----------------------------------------------------------------------------
module bvts_ctrl
    import bvts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_ctl_cmd   o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_sel = RES_NONE;
        o_busy  = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_IDLE;
                unique case (i_status.kind)
                    KIND_UPDATE: begin
                        o_cmd.wr_row  = i_status.upd_ok;
                        o_cmd.done    = 1'b1;
                        o_cmd.res_sel = RES_UPDATE;
                    end
                    KIND_SEARCH: begin
                        if (i_status.miss) begin
                            o_cmd.done    = 1'b1;
                            o_cmd.res_sel = RES_MISS;
                        end else begin
                            o_cmd.srch_start = 1'b1;
                            n_state          = S_PROBE;
                        end
                    end
                    KIND_READ: begin
                        o_cmd.done    = 1'b1;
                        o_cmd.res_sel = RES_READ;
                    end
                    default: begin
                        o_cmd.done    = 1'b1;
                        o_cmd.res_sel = RES_NONE;
                    end
                endcase
            end
            S_PROBE: begin
                if (i_status.probe_eq) begin
                    o_cmd.done    = 1'b1;
                    o_cmd.res_sel = RES_FOUND_MID;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.probe = 1'b1;
                    if (!i_status.probe_more) begin
                        o_cmd.done    = 1'b1;
                        o_cmd.res_sel = RES_FOUND_LO;
                        n_state       = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

@@ rtl/bvts_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvts_datapath
// Row memory, configuration registers, search bounds and result registers.
// ----------------------------------------------------------------------------
module bvts_datapath
    import bvts_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_ctl_cmd                     i_cmd,
    output t_dp_status                   o_status,
    // Item fields
    input  logic [KIND_BITS-1:0]         i_kind,
    input  logic [ROW_BITS-1:0]          i_row_index,
    input  logic [VALUE_BITS-1:0]        i_value,
    input  logic [CODE_BITS-1:0]         i_construction_code,
    input  logic signed [PARAM_BITS-1:0] i_param_a,
    input  logic signed [PARAM_BITS-1:0] i_param_b,
    input  logic signed [PARAM_BITS-1:0] i_param_c,
    input  logic signed [PARAM_BITS-1:0] i_param_d,
    input  logic signed [PARAM_BITS-1:0] i_param_e,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_BITS-1:0]         paddr,
    input  logic [DATA_BITS-1:0]         pwdata,
    output logic [DATA_BITS-1:0]         prdata,
    output logic                         pready,
    // Result
    output logic                         o_done,
    output logic [ROW_BITS-1:0]          o_found_index,
    output logic                         o_miss,
    output logic                         o_accepted,
    output logic [COUNT_BITS-1:0]        o_live_rows,
    output logic [VALUE_BITS-1:0]        o_row_value,
    output logic [CODE_BITS-1:0]         o_row_code,
    output logic signed [PARAM_BITS-1:0] o_row_param_a,
    output logic signed [PARAM_BITS-1:0] o_row_param_b,
    output logic signed [PARAM_BITS-1:0] o_row_param_c,
    output logic signed [PARAM_BITS-1:0] o_row_param_d,
    output logic signed [PARAM_BITS-1:0] o_row_param_e
);

    t_row r_mem [ROWS];
    t_row r_rd_data;

    logic [ROW_BITS-1:0]   r_clr_addr;
    logic [VALUE_BITS-1:0] r_cap;
    logic [COUNT_BITS-1:0] r_count;

    // Latched item
    logic [KIND_BITS-1:0]  r_kind;
    logic [ROW_BITS-1:0]   r_idx;
    logic [VALUE_BITS-1:0] r_key;
    logic [CODE_BITS-1:0]  r_code;
    logic [PARAM_BITS-1:0] r_pa;
    logic [PARAM_BITS-1:0] r_pb;
    logic [PARAM_BITS-1:0] r_pc;
    logic [PARAM_BITS-1:0] r_pd;
    logic [PARAM_BITS-1:0] r_pe;

    // Search window is [r_lo, r_end).
    logic [COUNT_BITS-1:0] r_lo;
    logic [COUNT_BITS-1:0] r_end;
    logic [ROW_BITS-1:0]   r_mid;

    logic                  r_done;
    logic [ROW_BITS-1:0]   r_found;
    logic                  r_miss;
    logic                  r_accepted;
    logic [COUNT_BITS-1:0] r_live;
    t_row                  r_res_row;

    logic [ROW_BITS-1:0]   rd_addr;
    logic                  wr_en;
    logic [ROW_BITS-1:0]   wr_addr;
    t_row                  wr_data;
    t_row                  clr_row;
    logic                  cfg_wr;
    logic [COUNT_BITS-1:0] limit_wr;
    logic [COUNT_BITS-1:0] count_m1;
    logic [ROW_BITS-1:0]   mid0;
    logic                  upd_ok;
    logic                  at_cap;
    logic [COUNT_BITS-1:0] n_count;
    logic                  probe_gt;
    logic [COUNT_BITS-1:0] n_lo;
    logic [COUNT_BITS-1:0] n_end;
    logic [COUNT_BITS:0]   mid_sum;
    logic [ROW_BITS-1:0]   n_mid;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign limit_wr = pwdata[COUNT_BITS-1:0];

    always_comb begin
        if (paddr[3] == REG_ROW_LIMIT) begin
            prdata = DATA_BITS'(r_count);
        end else begin
            prdata = DATA_BITS'(r_cap);
        end
    end

    always_comb begin
        clr_row         = '0;
        clr_row.value   = VALUE_BITS'(r_clr_addr);
        clr_row.code    = CODE_IDENTITY;
        clr_row.param_a = PARAM_BITS'(r_clr_addr);
    end

    assign count_m1 = r_count - COUNT_BITS'(1);
    assign mid0     = count_m1[COUNT_BITS-1:1];

    // Update check against the row just read.
    assign upd_ok  = (COUNT_BITS'(r_idx) < r_count) && (r_key > r_rd_data.value)
                     && (r_rd_data.value != r_cap);
    assign at_cap  = (r_key >= r_cap);
    assign n_count = (i_cmd.wr_row && at_cap) ? COUNT_BITS'(r_idx) + COUNT_BITS'(1)
                                              : r_count;

    // One probe: narrow the window and form the next midpoint.
    assign probe_gt = (r_rd_data.value > r_key);
    assign n_lo     = probe_gt ? r_lo : COUNT_BITS'(r_mid) + COUNT_BITS'(1);
    assign n_end    = probe_gt ? COUNT_BITS'(r_mid) : r_end;
    assign mid_sum  = {1'b0, n_lo} + {1'b0, n_end} - (COUNT_BITS + 1)'(1);
    assign n_mid    = mid_sum[ROW_BITS:1];

    always_comb begin
        if (i_cmd.load) begin
            rd_addr = (i_kind == KIND_SEARCH) ? count_m1[ROW_BITS-1:0] : i_row_index;
        end else if (i_cmd.srch_start) begin
            rd_addr = mid0;
        end else if (i_cmd.probe) begin
            rd_addr = n_mid;
        end else begin
            rd_addr = r_idx;
        end
    end

    always_comb begin
        wr_en   = i_cmd.clear || i_cmd.wr_row;
        wr_addr = i_cmd.clear ? r_clr_addr : r_idx;
        if (i_cmd.clear) begin
            wr_data = clr_row;
        end else begin
            wr_data.value   = at_cap ? r_cap : r_key;
            wr_data.code    = r_code;
            wr_data.param_a = r_pa;
            wr_data.param_b = r_pb;
            wr_data.param_c = r_pc;
            wr_data.param_d = r_pd;
            wr_data.param_e = r_pe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_cap      <= '1;
            r_count    <= COUNT_BITS'(ROWS);
            r_done     <= 1'b0;
        end else begin
            r_done <= i_cmd.done;
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + ROW_BITS'(1);
            end
            if (cfg_wr) begin
                if (paddr[3] == REG_VALUE_CAP) begin
                    r_cap <= pwdata[VALUE_BITS-1:0];
                end else if (limit_wr == '0) begin
                    r_count <= COUNT_BITS'(1);
                end else if (limit_wr > COUNT_BITS'(ROWS)) begin
                    r_count <= COUNT_BITS'(ROWS);
                end else begin
                    r_count <= limit_wr;
                end
            end else begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_idx  <= i_row_index;
            r_key  <= i_value;
            r_code <= i_construction_code;
            r_pa   <= i_param_a;
            r_pb   <= i_param_b;
            r_pc   <= i_param_c;
            r_pd   <= i_param_d;
            r_pe   <= i_param_e;
        end
        if (i_cmd.srch_start) begin
            r_lo  <= '0;
            r_end <= r_count;
            r_mid <= mid0;
        end else if (i_cmd.probe) begin
            r_lo  <= n_lo;
            r_end <= n_end;
            r_mid <= n_mid;
        end
        if (i_cmd.done) begin
            r_live     <= n_count;
            r_miss     <= (i_cmd.res_sel == RES_MISS);
            r_accepted <= (i_cmd.res_sel == RES_UPDATE) && upd_ok;
            r_res_row  <= (i_cmd.res_sel == RES_READ) ? r_rd_data : '0;
            case (i_cmd.res_sel)
                RES_FOUND_MID: r_found <= r_mid;
                RES_FOUND_LO:  r_found <= n_lo[ROW_BITS-1:0];
                default:       r_found <= '0;
            endcase
        end
    end

    always_comb begin
        o_status            = '0;
        o_status.clear_last = (r_clr_addr == ROW_BITS'(ROWS - 1));
        o_status.kind       = r_kind;
        o_status.upd_ok     = upd_ok;
        o_status.miss       = (r_rd_data.value < r_key);
        o_status.probe_eq   = (r_rd_data.value == r_key);
        o_status.probe_more = (n_lo < n_end);
    end

    assign o_done        = r_done;
    assign o_found_index = r_found;
    assign o_miss        = r_miss;
    assign o_accepted    = r_accepted;
    assign o_live_rows   = r_live;
    assign o_row_value   = r_res_row.value;
    assign o_row_code    = r_res_row.code;
    assign o_row_param_a = r_res_row.param_a;
    assign o_row_param_b = r_res_row.param_b;
    assign o_row_param_c = r_res_row.param_c;
    assign o_row_param_d = r_res_row.param_d;
    assign o_row_param_e = r_res_row.param_e;

endmodule

@@ rtl/best_value_table_search_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_value_table_search_unit
// Table of best values with capped update, lower-bound search and row read.
// ----------------------------------------------------------------------------
// Update, read and search miss: item latch and row read, then result strobe.
// Other searches: latch and last-row check, then binary-search probes on the
// row memory's single read port (at most eleven probes over 1024 rows).
// A new start is taken in the cycle the result strobe is shown.
// Reset clears all 1024 rows of the row memory in one pass; busy stays high
// until it ends. Results cannot be stalled by the receiver.
module best_value_table_search_unit
    import bvts_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [KIND_BITS-1:0]         i_kind,
    input  logic [ROW_BITS-1:0]          i_row_index,
    input  logic [VALUE_BITS-1:0]        i_value,
    input  logic [CODE_BITS-1:0]         i_construction_code,
    input  logic signed [PARAM_BITS-1:0] i_param_a,
    input  logic signed [PARAM_BITS-1:0] i_param_b,
    input  logic signed [PARAM_BITS-1:0] i_param_c,
    input  logic signed [PARAM_BITS-1:0] i_param_d,
    input  logic signed [PARAM_BITS-1:0] i_param_e,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_BITS-1:0]         paddr,
    input  logic [DATA_BITS-1:0]         pwdata,
    output logic [DATA_BITS-1:0]         prdata,
    output logic                         pready,
    output logic                         o_done,
    output logic [ROW_BITS-1:0]          o_found_index,
    output logic                         o_miss,
    output logic                         o_accepted,
    output logic [COUNT_BITS-1:0]        o_live_rows,
    output logic [VALUE_BITS-1:0]        o_row_value,
    output logic [CODE_BITS-1:0]         o_row_code,
    output logic signed [PARAM_BITS-1:0] o_row_param_a,
    output logic signed [PARAM_BITS-1:0] o_row_param_b,
    output logic signed [PARAM_BITS-1:0] o_row_param_c,
    output logic signed [PARAM_BITS-1:0] o_row_param_d,
    output logic signed [PARAM_BITS-1:0] o_row_param_e
);

    t_ctl_cmd   cmd;
    t_dp_status status;

    bvts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    bvts_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_kind              (i_kind),
        .i_row_index         (i_row_index),
        .i_value             (i_value),
        .i_construction_code (i_construction_code),
        .i_param_a           (i_param_a),
        .i_param_b           (i_param_b),
        .i_param_c           (i_param_c),
        .i_param_d           (i_param_d),
        .i_param_e           (i_param_e),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .o_done              (o_done),
        .o_found_index       (o_found_index),
        .o_miss              (o_miss),
        .o_accepted          (o_accepted),
        .o_live_rows         (o_live_rows),
        .o_row_value         (o_row_value),
        .o_row_code          (o_row_code),
        .o_row_param_a       (o_row_param_a),
        .o_row_param_b       (o_row_param_b),
        .o_row_param_c       (o_row_param_c),
        .o_row_param_d       (o_row_param_d),
        .o_row_param_e       (o_row_param_e)
    );

endmodule
